// ----- rtl/pws_pkg.sv -----
`default_nettype none

package pws_pkg;

  localparam logic [1:0] ACT_PALETTE = 2'd0;
  localparam logic [1:0] ACT_WINDOW  = 2'd1;
  localparam logic [1:0] ACT_PIXEL   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ORIGIN    = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NO_WINDOW = 2'd3;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  localparam logic [3:0] WIN_LAST_STEP = 4'd10;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  palette_entry;
    logic [23:0] palette_color;
    logic [9:0]  win_x;
    logic [9:0]  win_y;
    logic [9:0]  win_w;
    logic [9:0]  win_h;
    logic [7:0]  pixel_index;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       end_select;
    logic [1:0] status;
    logic       last;
  } result_t;

  function automatic logic [15:0] pack565(input logic [23:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pws_ram.sv -----
`default_nettype none

module pws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/palette_window_pixel_streamer.sv -----
// Indexed-color pixel streamer for an SPI RGB565 display.
// Input channel (item, item_valid, item_stall) takes one word per action:
// palette write, window start or pixel index. Output channel (result,
// result_valid, result_stall) gives the SPI byte stream with its
// data/command flag, chip-select release mark, status and last-of-item mark.
// An accepted window or pixel word is registered into the work stage and
// its results leave through a single output register; a palette write gives
// no result. Results leave at one per cycle unless result_stall holds them;
// a window start gives 11 results (1 on error), a pixel 2 (1 with no open
// window), and the next word is accepted as the last result is handed over.
// The per-pixel rate is set by the two output bytes per pixel through the
// one output register; the palette is a 1-read 1-write RAM read at accept.
// Reset empties the pipeline, closes any open window and marks every
// palette slot as unwritten, so it reads as color zero; no clearing pass.
// A stalled valid result holds the output register and the item in work.
// item_stall is high while an item is in work and drops only in the cycle
// in which its last result moves into the output register.
`default_nettype none

module palette_window_pixel_streamer
  import pws_pkg::*;
#(
  parameter int PANEL_WIDTH  = 240,
  parameter int PANEL_HEIGHT = 320,
  parameter int PALETTE_SIZE = 256
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire item_t   item,
  input  wire logic    item_valid,
  output logic         item_stall,
  output result_t      result,
  output logic         result_valid,
  input  wire logic    result_stall
);

  localparam int PAL_AW = $clog2(PALETTE_SIZE);
  localparam int PIX_W  = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1);
  localparam logic [10:0] PW = 11'(PANEL_WIDTH);
  localparam logic [10:0] PH = 11'(PANEL_HEIGHT);
  localparam logic [8:0]  PS = 9'(PALETTE_SIZE);

  logic              accept;
  logic              pal_we;
  logic              pix_re;
  logic              in_range;
  logic [15:0]       rd_data;
  logic [PALETTE_SIZE-1:0] pal_valid;
  logic              origin_bad;
  logic              size_empty;
  logic [10:0]       w_clip;
  logic [10:0]       h_clip;

  logic              s1_valid;
  logic              s1_window;
  logic [1:0]        s1_status;
  logic [9:0]        s1_x;
  logic [9:0]        s1_y;
  logic [10:0]       s1_w;
  logic [10:0]       s1_h;
  logic              s1_hit;
  logic [3:0]        cnt;
  logic [PIX_W-1:0]  pixels_left;

  logic              emit;
  logic              last_res;
  logic              pix_open;
  logic [9:0]        x1;
  logic [9:0]        y1;
  logic [15:0]       color;
  logic [21:0]       win_area;
  result_t           res_next;

  assign emit       = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !(emit && last_res);
  assign accept     = item_valid && !item_stall;

  assign in_range = {1'b0, item.pixel_index} < PS;
  assign pal_we   = accept && (item.action == ACT_PALETTE) && ({1'b0, item.palette_entry} < PS);
  assign pix_re   = accept && (item.action == ACT_PIXEL);

  pws_ram #(
    .WIDTH(16),
    .DEPTH(PALETTE_SIZE)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(item.palette_entry[PAL_AW-1:0]),
    .wdata(pack565(item.palette_color)),
    .re   (pix_re),
    .raddr(item.pixel_index[PAL_AW-1:0]),
    .rdata(rd_data)
  );

  // window clipping at accept
  assign origin_bad = ({1'b0, item.win_x} >= PW) || ({1'b0, item.win_y} >= PH);
  assign size_empty = (item.win_w == 10'd0) || (item.win_h == 10'd0);
  assign w_clip = (({1'b0, item.win_x} + {1'b0, item.win_w}) > PW) ?
                  (PW - {1'b0, item.win_x}) : {1'b0, item.win_w};
  assign h_clip = (({1'b0, item.win_y} + {1'b0, item.win_h}) > PH) ?
                  (PH - {1'b0, item.win_y}) : {1'b0, item.win_h};

  assign x1       = 10'({1'b0, s1_x} + s1_w - 11'd1);
  assign y1       = 10'({1'b0, s1_y} + s1_h - 11'd1);
  assign color    = s1_hit ? rd_data : 16'd0;
  assign win_area = 22'(s1_w * s1_h);
  assign pix_open = pixels_left != '0;

  always_comb begin
    res_next = '0;
    last_res = 1'b1;
    if (s1_window) begin
      if (s1_status != ST_OK) begin
        res_next.status = s1_status;
        res_next.last   = 1'b1;
      end else begin
        last_res         = (cnt == WIN_LAST_STEP);
        res_next.is_data = 1'b1;
        case (cnt)
          4'd0: begin
            res_next.out_byte = CMD_COLUMN_SET;
            res_next.is_data  = 1'b0;
          end
          4'd1: res_next.out_byte = {6'd0, s1_x[9:8]};
          4'd2: res_next.out_byte = s1_x[7:0];
          4'd3: res_next.out_byte = {6'd0, x1[9:8]};
          4'd4: begin
            res_next.out_byte   = x1[7:0];
            res_next.end_select = 1'b1;
          end
          4'd5: begin
            res_next.out_byte = CMD_ROW_SET;
            res_next.is_data  = 1'b0;
          end
          4'd6: res_next.out_byte = {6'd0, s1_y[9:8]};
          4'd7: res_next.out_byte = s1_y[7:0];
          4'd8: res_next.out_byte = {6'd0, y1[9:8]};
          4'd9: begin
            res_next.out_byte   = y1[7:0];
            res_next.end_select = 1'b1;
          end
          default: begin
            res_next.out_byte = CMD_MEMORY_WRITE;
            res_next.is_data  = 1'b0;
            res_next.last     = 1'b1;
          end
        endcase
      end
    end else if (!pix_open) begin
      res_next.status = ST_NO_WINDOW;
      res_next.last   = 1'b1;
    end else begin
      last_res         = (cnt != 4'd0);
      res_next.is_data = 1'b1;
      if (cnt == 4'd0) begin
        res_next.out_byte = color[15:8];
      end else begin
        res_next.out_byte   = color[7:0];
        res_next.end_select = (pixels_left == PIX_W'(1));
        res_next.last       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid    <= '0;
      s1_valid     <= 1'b0;
      cnt          <= '0;
      pixels_left  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (pal_we) begin
        pal_valid[item.palette_entry[PAL_AW-1:0]] <= 1'b1;
      end
      if (accept && (item.action == ACT_WINDOW || item.action == ACT_PIXEL)) begin
        s1_valid <= 1'b1;
      end else if (emit && last_res) begin
        s1_valid <= 1'b0;
      end
      if (emit) begin
        cnt <= last_res ? 4'd0 : cnt + 4'd1;
      end
      if (s1_valid && s1_window) begin
        pixels_left <= (s1_status == ST_OK) ? win_area[PIX_W-1:0] : '0;
      end else if (emit && last_res && !s1_window && pix_open) begin
        pixels_left <= pixels_left - PIX_W'(1);
      end
      if (!result_valid || !result_stall) begin
        result_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_window <= (item.action == ACT_WINDOW);
      s1_status <= origin_bad ? ST_ORIGIN : (size_empty ? ST_EMPTY : ST_OK);
      s1_x      <= item.win_x;
      s1_y      <= item.win_y;
      s1_w      <= w_clip;
      s1_h      <= h_clip;
      s1_hit    <= in_range && pal_valid[item.pixel_index[PAL_AW-1:0]];
    end
    if (emit) begin
      result <= res_next;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> cnt <= WIN_LAST_STEP)
    else $error("step count beyond window sequence");

  a_enter_stage: assert property (@(posedge clk) disable iff (rst)
    accept && (item.action == ACT_WINDOW || item.action == ACT_PIXEL) |=> s1_valid)
    else $error("accepted word did not enter work stage");

  a_release_on_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.end_select |-> result.is_data && result.status == ST_OK)
    else $error("select release on non-data byte");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |-> result.last && !result.is_data)
    else $error("error result not a lone last result");

  a_window_close: assert property (@(posedge clk) disable iff (rst)
    emit && last_res && !s1_window && pixels_left == PIX_W'(1) |=> pixels_left == '0)
    else $error("last pixel did not close window");

endmodule

`default_nettype wire
